[design/slbs_pkg.sv]
// Shared constants and control/status types for the lower-bound search block.
package slbs_pkg;

    localparam int FIELD_W     = 32;   // width of value and key ports
    localparam int ENTRY_IDX_W = 10;   // width of the write index port
    localparam int POS_W       = 11;   // width of range bounds and position
    localparam int CMP_W       = 18;   // holds any index and the largest depth

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic wr;      // write table entry from the ports
        logic load;    // capture range and key of a search word
        logic walk;    // narrow the range, issue next table read
        logic probe;   // read data belongs to a midpoint probe
        logic last;    // read data belongs to the final single-entry check
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;   // candidate range holds no entry
        logic many;    // candidate range holds two or more entries
    } stat_t;

endpackage

[design/slbs_ctrl.sv]
// Controller state machine for the lower-bound search block.
module slbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                command,
    input  slbs_pkg::stat_t     stat,
    output slbs_pkg::ctrl_t     ctrl,
    output logic                busy,
    output logic                done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_PROBE,
        S_LAST
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        ctrl.wr    = accept && (command == slbs_pkg::CMD_WRITE);
        ctrl.load  = accept && (command == slbs_pkg::CMD_SEARCH);
        ctrl.walk  = (state_reg == S_WALK) || (state_reg == S_PROBE);
        ctrl.probe = (state_reg == S_PROBE);
        ctrl.last  = (state_reg == S_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.load)
                    begin
                        state_reg <= S_WALK;
                        busy_reg  <= 1'b1;
                    end
                end
                S_WALK, S_PROBE:
                begin
                    if (stat.empty)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else if (stat.many)
                    begin
                        state_reg <= S_PROBE;
                    end
                    else
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && (state_reg == S_IDLE))
        else $error("result strobe while search still running");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> busy_reg && (state_reg == S_WALK))
        else $error("accepted search did not start");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr |=> !busy_reg && !done_reg)
        else $error("write word caused activity");

    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with state");

endmodule

[design/slbs_datapath.sv]
// Datapath: table memory, range registers, midpoint and compare logic.
module slbs_datapath #(
    parameter int TABLE_DEPTH = slbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = slbs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                 clk,
    input  slbs_pkg::ctrl_t                      ctrl,
    input  logic [slbs_pkg::ENTRY_IDX_W-1:0]     entry_index,
    input  logic signed [slbs_pkg::FIELD_W-1:0]  entry_value,
    input  logic [slbs_pkg::POS_W-1:0]           range_begin,
    input  logic [slbs_pkg::POS_W-1:0]           range_end,
    input  logic signed [slbs_pkg::FIELD_W-1:0]  search_key,
    output slbs_pkg::stat_t                      stat,
    output logic [slbs_pkg::POS_W-1:0]           position
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int POS_W = slbs_pkg::POS_W;
    localparam int CMP_W = slbs_pkg::CMP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

    logic signed [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;
    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic [POS_W-1:0]              lo_reg;
    logic [POS_W-1:0]              hi_reg;
    logic [POS_W-1:0]              mid_reg;
    logic [POS_W-1:0]              pos_reg;

    logic [POS_W-1:0] cand_lo;
    logic [POS_W-1:0] cand_hi;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] mid_next;
    logic [POS_W-1:0] rd_addr;
    logic [POS_W-1:0] sat_begin;
    logic [POS_W-1:0] sat_end;
    logic             wr_ok;
    logic             below;

    // bounds past the table clamp to its depth
    assign sat_begin = ({{(CMP_W-POS_W){1'b0}}, range_begin} > DEPTH_C)
                       ? POS_W'(TABLE_DEPTH) : range_begin;
    assign sat_end   = ({{(CMP_W-POS_W){1'b0}}, range_end} > DEPTH_C)
                       ? POS_W'(TABLE_DEPTH) : range_end;

    assign wr_ok = ctrl.wr &&
                   ({{(CMP_W-slbs_pkg::ENTRY_IDX_W){1'b0}}, entry_index} < DEPTH_C);

    assign below = rd_data_reg < key_reg;

    always_comb
    begin
        if (ctrl.probe)
        begin
            cand_lo = below ? (mid_reg + POS_W'(1)) : lo_reg;
            cand_hi = below ? hi_reg : mid_reg;
        end
        else
        begin
            cand_lo = lo_reg;
            cand_hi = hi_reg;
        end
        span       = cand_hi - cand_lo;
        mid_next   = cand_lo + (span >> 1);
        stat.empty = cand_lo >= cand_hi;
        stat.many  = !stat.empty && (span[POS_W-1:1] != '0);
        // single entry left: read it at lo
        rd_addr    = stat.many ? mid_next : cand_lo;
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            table_mem[AW'(entry_index)] <= VALUE_WIDTH'(entry_value);
        end
        rd_data_reg <= table_mem[AW'(rd_addr)];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            lo_reg  <= sat_begin;
            hi_reg  <= sat_end;
            key_reg <= VALUE_WIDTH'(search_key);
        end
        else if (ctrl.walk)
        begin
            lo_reg  <= cand_lo;
            hi_reg  <= cand_hi;
            mid_reg <= mid_next;
        end

        if (ctrl.walk && stat.empty)
        begin
            pos_reg <= cand_hi;
        end
        else if (ctrl.last)
        begin
            pos_reg <= below ? hi_reg : lo_reg;
        end
    end

    assign position = pos_reg;

endmodule

[design/sorted_table_lower_bound_search.sv]
// Top level of the lower-bound search block over a loaded table of signed values.
// A write word is taken when start is accepted; busy stays low and no result follows.
// A search narrows its range by midpoint probes and then strobes done, with
// one registered table read per probe of the table memory.
// The next word is taken in the done cycle.
// Reset clears the controller only; table entries are undefined until written.
module sorted_table_lower_bound_search #(
    parameter int TABLE_DEPTH = slbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = slbs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 command,
    input  logic [slbs_pkg::ENTRY_IDX_W-1:0]     entry_index,
    input  logic signed [slbs_pkg::FIELD_W-1:0]  entry_value,
    input  logic [slbs_pkg::POS_W-1:0]           range_begin,
    input  logic [slbs_pkg::POS_W-1:0]           range_end,
    input  logic signed [slbs_pkg::FIELD_W-1:0]  search_key,
    output logic                                 done,
    output logic [slbs_pkg::POS_W-1:0]           position
);

    slbs_pkg::ctrl_t ctrl;
    slbs_pkg::stat_t stat;

    slbs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy),
        .done    (done)
    );

    slbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .ctrl        (ctrl),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .range_begin (range_begin),
        .range_end   (range_end),
        .search_key  (search_key),
        .stat        (stat),
        .position    (position)
    );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the lower-bound search block: table loads, searches, and checks.
module tb_top;
    import slbs_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          command;
    logic [ENTRY_IDX_W-1:0]        entry_index;
    logic signed [FIELD_W-1:0]     entry_value;
    logic [POS_W-1:0]              range_begin;
    logic [POS_W-1:0]              range_end;
    logic signed [FIELD_W-1:0]     search_key;
    logic                          done;
    logic [POS_W-1:0]              position;

    // Mirror of the table contents and which entries have been loaded.
    logic signed [FIELD_W-1:0]     mirror_vals [DEPTH];
    bit                            mirror_written [DEPTH];
    logic [POS_W-1:0]              pending_positions [$];
    logic [POS_W-1:0]              expected_pos;

    int fail_count;
    int n_writes;
    int n_searches;
    int n_results;
    int idle_pct;
    int sweep_next;

    sorted_table_lower_bound_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .range_begin (range_begin),
        .range_end   (range_end),
        .search_key  (search_key),
        .done        (done),
        .position    (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [POS_W-1:0] lower_bound_of(input logic [POS_W-1:0] rb,
                                                        input logic [POS_W-1:0] re,
                                                        input logic signed [FIELD_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = (int'(rb) > DEPTH) ? DEPTH : int'(rb);
        hi = (int'(re) > DEPTH) ? DEPTH : int'(re);
        if (lo >= hi)
            return POS_W'(hi);
        while (hi - lo >= 2)
        begin
            mid = lo + (hi - lo) / 2;
            if (mirror_vals[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo < hi && mirror_vals[lo] >= key)
            return POS_W'(lo);
        return POS_W'(hi);
    endfunction

    // Entered just after a falling edge; returns just after a falling edge.
    task automatic send_word(input logic cmd,
                             input logic [ENTRY_IDX_W-1:0] idx,
                             input logic signed [FIELD_W-1:0] val,
                             input logic [POS_W-1:0] rb,
                             input logic [POS_W-1:0] re,
                             input logic signed [FIELD_W-1:0] key);
        start       <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        entry_value <= val;
        range_begin <= rb;
        range_end   <= re;
        search_key  <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd == CMD_WRITE)
        begin
            mirror_vals[idx]    = val;
            mirror_written[idx] = 1'b1;
            n_writes++;
        end
        else
        begin
            pending_positions.push_back(lower_bound_of(rb, re, key));
            n_searches++;
        end
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Fields that a word does not use carry random junk.
    task automatic write_entry(input logic [ENTRY_IDX_W-1:0] idx,
                               input logic signed [FIELD_W-1:0] val);
        send_word(CMD_WRITE, idx, val, POS_W'($urandom), POS_W'($urandom), $urandom);
    endtask

    task automatic search_range(input logic [POS_W-1:0] rb,
                                input logic [POS_W-1:0] re,
                                input logic signed [FIELD_W-1:0] key);
        send_word(CMD_SEARCH, ENTRY_IDX_W'($urandom), $urandom, rb, re, key);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_positions.size() == 0)
            begin
                $error("position: no search outstanding, got %0d", position);
                fail_count++;
            end
            else
            begin
                expected_pos = pending_positions.pop_front();
                n_results++;
                if (position !== expected_pos)
                begin
                    $error("position: expected %0d, got %0d", expected_pos, position);
                    fail_count++;
                end
            end
        end
    end

    // Sorted top block with duplicates and both extremes, then edge-case ranges.
    task automatic test_directed_corners();
        logic signed [FIELD_W-1:0] corner_vals [16];
        int k;
        corner_vals = '{VAL_MIN, VAL_MIN, -32'sd5, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1,
                        32'sd7, 32'sd100, 32'sd100, 32'sd1000, 32'sh4000_0000,
                        32'sh7fff_fffe, VAL_MAX, VAL_MAX};
        idle_pct = 0;
        for (k = 0; k < 16; k++)
            write_entry(ENTRY_IDX_W'(DEPTH - 16 + k), corner_vals[k]);
        search_range(11'd1008, 11'd1024, VAL_MIN);
        search_range(11'd1008, 11'd2047, VAL_MAX);
        search_range(11'd1008, 11'd1024, 32'sd0);
        search_range(11'd1008, 11'd1024, 32'sd8);
        search_range(11'd1013, 11'd1014, 32'sd1);
        search_range(11'd1016, 11'd1022, VAL_MAX);
        search_range(11'd1020, 11'd1020, 32'sd0);
        search_range(11'd1016, 11'd1010, 32'sd0);
        search_range(11'd1500, 11'd1100, 32'sd0);
        search_range(11'd2047, 11'd2047, VAL_MAX);
    endtask

    // Loads a sorted (sometimes unsorted) segment, then searches around loaded runs.
    task automatic test_random_traffic(input int pct, input int n_items);
        int issued;
        int seg_len;
        int seg_base;
        int n_find;
        int anchor;
        int rl;
        int rh;
        int pick;
        int k;
        int r;
        int unsigned step_max;
        longint acc;
        bit sorted_run;
        logic signed [FIELD_W-1:0] val;
        logic signed [FIELD_W-1:0] key;
        logic [POS_W-1:0] rb;
        logic [POS_W-1:0] re;
        idle_pct = pct;
        issued = 0;
        while (issued < n_items)
        begin
            seg_len = ($urandom_range(99) < 8) ? $urandom_range(64, 160) : $urandom_range(1, 16);
            seg_base = ($urandom_range(99) < 15) ? $urandom_range(0, DEPTH - 1) : sweep_next;
            if (seg_base + seg_len > DEPTH)
                seg_len = DEPTH - seg_base;
            if (seg_base == sweep_next)
                sweep_next = (seg_base + seg_len) % DEPTH;
            sorted_run = ($urandom_range(99) < 85);
            case ($urandom_range(2))
                0:       step_max = 3;
                1:       step_max = 1000;
                default: step_max = 1 << 26;
            endcase
            acc = ($urandom_range(9) == 0) ? longint'(VAL_MIN) : longint'($signed($urandom));
            for (k = 0; k < seg_len; k++)
            begin
                if (sorted_run)
                begin
                    val = FIELD_W'(acc);
                    acc += $urandom_range(0, step_max);
                    if (acc > longint'(VAL_MAX))
                        acc = longint'(VAL_MAX);
                end
                else
                    val = $urandom;
                write_entry(ENTRY_IDX_W'(seg_base + k), val);
            end
            issued += seg_len;

            n_find = $urandom_range(4, 16);
            for (k = 0; k < n_find; k++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    // empty or inverted, anywhere in the 11-bit space
                    rb  = POS_W'($urandom_range(0, 2047));
                    re  = POS_W'($urandom_range(0, rb));
                    key = $urandom;
                end
                else
                begin
                    anchor = seg_base + $urandom_range(0, seg_len - 1);
                    if ($urandom_range(1))
                    begin
                        repeat (8)
                        begin
                            pick = $urandom_range(0, DEPTH - 1);
                            if (mirror_written[pick])
                            begin
                                anchor = pick;
                                break;
                            end
                        end
                    end
                    // only search inside a fully loaded run
                    rl = anchor;
                    while (rl > 0 && mirror_written[rl - 1])
                        rl--;
                    rh = anchor + 1;
                    while (rh < DEPTH && mirror_written[rh])
                        rh++;
                    if ($urandom_range(99) < 30)
                    begin
                        rb = POS_W'(rl);
                        re = POS_W'(rh);
                    end
                    else
                    begin
                        rb = POS_W'($urandom_range(rl, anchor));
                        re = POS_W'($urandom_range(anchor + 1, rh));
                    end
                    pick = $urandom_range(int'(rb), int'(re) - 1);
                    if (int'(re) == DEPTH && $urandom_range(1))
                        re = POS_W'($urandom_range(DEPTH, 2047));
                    r = $urandom_range(99);
                    if (r < 40)
                        key = mirror_vals[pick];
                    else if (r < 60)
                        key = $urandom_range(1) ? mirror_vals[pick] + 32'sd1
                                                : mirror_vals[pick] - 32'sd1;
                    else if (r < 85)
                        key = $urandom;
                    else
                        key = $urandom_range(1) ? VAL_MAX : VAL_MIN;
                end
                search_range(rb, re, key);
            end
            issued += n_find;
        end
    endtask

    initial
    begin
        int k;
        int loaded;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_WRITE;
        entry_index = '0;
        entry_value = '0;
        range_begin = '0;
        range_end   = '0;
        search_key  = '0;
        fail_count  = 0;
        n_writes    = 0;
        n_searches  = 0;
        n_results   = 0;
        idle_pct    = 0;
        sweep_next  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_corners();
        test_random_traffic(17, 375);
        test_random_traffic(56, 375);
        test_random_traffic(0, 375);
        start <= 1'b0;

        k = 0;
        while (pending_positions.size() != 0 && k < 200)
        begin
            @(posedge clk);
            k++;
        end
        repeat (20) @(posedge clk);
        if (pending_positions.size() != 0)
        begin
            $error("position: %0d searches never answered", pending_positions.size());
            fail_count += pending_positions.size();
        end

        loaded = 0;
        for (k = 0; k < DEPTH; k++)
            loaded += mirror_written[k];
        $display("Ran %0d table writes and %0d searches, %0d positions checked.",
                 n_writes, n_searches, n_results);
        $display("Sender idle at 17, 56 and 0 percent; %0d of %0d entries loaded.",
                 loaded, DEPTH);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
